@@ src/pts_pkg.sv @@
// Shared types and constants for the priority task scheduler.
`default_nettype none

package pts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam logic [7:0]  IDLE_PRIO_RESET = 8'd100;
  localparam logic [7:0]  IDLE_TASK_ID    = 8'd1;
  localparam logic [7:0]  FIRST_NEW_ID    = 8'd2;
  localparam logic [7:0]  LAST_ID         = 8'd255;
  localparam logic [15:0] WAKE_NEVER      = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELAY  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_NO_TASK = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CR_READ,
    ST_CR_CHECK,
    ST_CR_PUT,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic        ready;
    logic [15:0] wake;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  priority_req;
    logic [15:0] delay_ticks;
  } cmd_beat_t;

  typedef struct packed {
    logic [7:0]  running_task_id;
    logic        switched;
    err_t        error_code;
    logic [15:0] tick_value;
    logic [15:0] switch_count;
    logic [4:0]  task_total;
  } res_beat_t;

endpackage

`default_nettype wire

@@ src/pts_table_ram.sv @@
// Simple dual-port task table memory, one write and one registered read port.
`default_nettype none

module pts_table_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/pts_ctrl.sv @@
// Scheduler sequencer: sorted insert, tick/delay sweep and task selection.
`default_nettype none

module pts_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [7:0]                cfg_wdata,
  input  wire logic                      cmd_valid,
  input  wire pts_pkg::cmd_beat_t        cmd_data,
  output logic                           cmd_stall,
  input  wire logic                      out_ready,
  output logic                           res_load,
  output pts_pkg::res_beat_t             result,
  output pts_pkg::mem_req_t              mem_req,
  input  wire logic [pts_pkg::ENTRY_W-1:0] mem_rdata
);

  pts_pkg::state_t state, state_next;

  logic [7:0]                  idle_prio;
  logic [15:0]                 tick;
  logic [7:0]                  cur;
  logic [15:0]                 switches;
  logic [pts_pkg::CNT_W-1:0]   count;
  logic [7:0]                  next_id;
  logic                        running;

  pts_pkg::cmd_t               cmd;
  logic [7:0]                  prio_req;
  logic [15:0]                 dticks;
  pts_pkg::err_t               err;

  logic [pts_pkg::IDX_W-1:0]   ptr;
  logic [pts_pkg::IDX_W-1:0]   ins_pos;
  logic [pts_pkg::CNT_W-1:0]   issue_idx;
  logic                        pend;
  logic [pts_pkg::IDX_W-1:0]   pend_idx;
  logic                        delay_hit;
  logic                        sel_found;
  logic [7:0]                  sel_id;

  pts_pkg::entry_t e_rd;
  pts_pkg::entry_t e_upd;
  logic            upd_wr;
  logic            upd_hit;
  logic            upd_pick;
  logic            issue;
  logic            shift_up;
  logic            accept;
  logic            do_switch;
  logic            table_full;

  assign e_rd       = pts_pkg::entry_t'(mem_rdata);
  assign accept     = cmd_valid && (state == pts_pkg::ST_IDLE);
  assign cmd_stall  = (state != pts_pkg::ST_IDLE);
  assign issue      = (issue_idx < count);
  assign shift_up   = (e_rd.prio > prio_req);
  assign table_full = (count >= pts_pkg::CNT_W'(pts_pkg::MAX_TASKS));
  assign do_switch  = running && sel_found && (sel_id != cur);

  // Per-entry update during a sweep; selection sees the updated ready flag.
  always_comb begin
    e_upd   = e_rd;
    upd_wr  = 1'b0;
    upd_hit = 1'b0;
    if (cmd == pts_pkg::CMD_TICK && e_rd.wake == tick) begin
      e_upd.ready = 1'b1;
      upd_wr      = 1'b1;
    end
    if (cmd == pts_pkg::CMD_DELAY && cur != 8'd0 && !delay_hit && e_rd.id == cur) begin
      e_upd.wake  = tick + dticks;
      e_upd.ready = 1'b0;
      upd_wr      = 1'b1;
      upd_hit     = 1'b1;
    end
    upd_pick = running && !sel_found && e_upd.ready;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= pts_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_req    = '0;
    res_load   = 1'b0;
    unique case (state)
      pts_pkg::ST_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = '0;
        mem_req.wr_data = '{id: pts_pkg::IDLE_TASK_ID, prio: idle_prio, ready: 1'b1,
                            wake: pts_pkg::WAKE_NEVER};
        state_next      = pts_pkg::ST_IDLE;
      end
      pts_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_data.command == pts_pkg::CMD_CREATE && !table_full) begin
            state_next = pts_pkg::ST_CR_READ;
          end else begin
            state_next = pts_pkg::ST_SWEEP;
          end
        end
      end
      pts_pkg::ST_CR_READ: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ptr;
        state_next      = pts_pkg::ST_CR_CHECK;
      end
      pts_pkg::ST_CR_CHECK: begin
        if (shift_up) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ptr + pts_pkg::IDX_W'(1);
          mem_req.wr_data = e_rd;
          state_next      = (ptr == '0) ? pts_pkg::ST_CR_PUT : pts_pkg::ST_CR_READ;
        end else begin
          state_next = pts_pkg::ST_CR_PUT;
        end
      end
      pts_pkg::ST_CR_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ins_pos;
        mem_req.wr_data = '{id: next_id, prio: prio_req, ready: 1'b1,
                            wake: pts_pkg::WAKE_NEVER};
        state_next      = pts_pkg::ST_SWEEP;
      end
      pts_pkg::ST_SWEEP: begin
        // read of entry i overlaps the write-back of entry i-1
        if (issue) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = issue_idx[pts_pkg::IDX_W-1:0];
        end
        if (pend && upd_wr) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pend_idx;
          mem_req.wr_data = e_upd;
        end
        if (!issue && !pend) begin
          state_next = pts_pkg::ST_DONE;
        end
      end
      pts_pkg::ST_DONE: begin
        if (out_ready) begin
          res_load   = 1'b1;
          state_next = pts_pkg::ST_IDLE;
        end
      end
      default: state_next = pts_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    result.running_task_id = do_switch ? sel_id : cur;
    result.switched        = do_switch;
    result.error_code      = err;
    result.tick_value      = tick;
    result.switch_count    = switches + 16'(do_switch);
    result.task_total      = 5'(count);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      idle_prio <= rst ? pts_pkg::IDLE_PRIO_RESET : cfg_wdata;
      tick      <= '0;
      cur       <= '0;
      switches  <= '0;
      count     <= pts_pkg::CNT_W'(1);
      next_id   <= pts_pkg::FIRST_NEW_ID;
      running   <= 1'b0;
      pend      <= 1'b0;
      delay_hit <= 1'b0;
      sel_found <= 1'b0;
    end else begin
      unique case (state)
        pts_pkg::ST_IDLE: begin
          if (accept) begin
            cmd       <= cmd_data.command;
            prio_req  <= cmd_data.priority_req;
            dticks    <= cmd_data.delay_ticks;
            ptr       <= pts_pkg::IDX_W'(count - pts_pkg::CNT_W'(1));
            issue_idx <= '0;
            pend      <= 1'b0;
            delay_hit <= 1'b0;
            sel_found <= 1'b0;
            err       <= pts_pkg::ERR_OK;
            unique case (cmd_data.command)
              pts_pkg::CMD_CREATE: if (table_full) err <= pts_pkg::ERR_FULL;
              pts_pkg::CMD_DELAY:  if (cur == 8'd0) err <= pts_pkg::ERR_NO_TASK;
              pts_pkg::CMD_TICK:   tick <= tick + 16'd1;
              pts_pkg::CMD_RUN:    running <= 1'b1;
            endcase
          end
        end
        pts_pkg::ST_CR_CHECK: begin
          if (shift_up) begin
            ins_pos <= '0;
            ptr     <= ptr - pts_pkg::IDX_W'(1);
          end else begin
            ins_pos <= ptr + pts_pkg::IDX_W'(1);
          end
        end
        pts_pkg::ST_CR_PUT: begin
          count   <= count + pts_pkg::CNT_W'(1);
          next_id <= (next_id == pts_pkg::LAST_ID) ? 8'd1 : next_id + 8'd1;
        end
        pts_pkg::ST_SWEEP: begin
          if (issue) begin
            issue_idx <= issue_idx + pts_pkg::CNT_W'(1);
          end
          pend     <= issue;
          pend_idx <= issue_idx[pts_pkg::IDX_W-1:0];
          if (pend && upd_hit) begin
            delay_hit <= 1'b1;
          end
          if (pend && upd_pick) begin
            sel_found <= 1'b1;
            sel_id    <= e_rd.id;
          end
        end
        pts_pkg::ST_DONE: begin
          if (out_ready && do_switch) begin
            cur      <= sel_id;
            switches <= switches + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/priority_task_scheduler.sv @@
// Top level of the priority task scheduler: sequencer, task table and result register.
//
//   channel   direction  handshake          beat
//   cmd       in         cmd_valid/stall    cmd_data   (command, priority_req, delay_ticks)
//   res       out        res_valid/stall    res_data   (running_task_id .. task_total)
//   cfg       in         cfg_we             cfg_wdata  (idle_priority)
//
// One command at a time. Tick, delay, run and a create on a full table go straight to a
// pipelined sweep of the table RAM; a create that fits first moves each entry of larger
// priority up one slot (read, then check and write) and then puts the new entry in place.
// The next command can be taken in the cycle after the result loads. rst (synchronous)
// and a cfg write rebuild the table; res_stall holds the sequencer only at completion.
`default_nettype none

module priority_task_scheduler (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire pts_pkg::cmd_beat_t  cmd_data,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output pts_pkg::res_beat_t       res_data
);

  pts_pkg::mem_req_t           mem_req;
  logic [pts_pkg::ENTRY_W-1:0] mem_rdata;
  pts_pkg::res_beat_t          result;
  logic                        res_load;
  logic                        out_ready;

  assign out_ready = !res_valid || !res_stall;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_stall (cmd_stall),
    .out_ready (out_ready),
    .res_load  (res_load),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  pts_table_ram #(
    .DEPTH (pts_pkg::MAX_TASKS),
    .WIDTH (pts_pkg::ENTRY_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rdata),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/pts_checker.sv @@
// Scoreboard for the priority task scheduler: task table predictor and result compare.
`default_nettype none

module pts_checker
  import pts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic      cmd_valid,
  input  wire logic      cmd_stall,
  input  wire cmd_beat_t cmd_data,
  input  wire logic      res_valid,
  input  wire logic      res_stall,
  input  wire res_beat_t res_data,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t      tbl [MAX_TASKS];
  logic [7:0]  idle_prio;
  logic [15:0] ticks_now;
  logic [7:0]  cur_id;
  logic [15:0] n_switches;
  int          n_tasks;
  logic [7:0]  id_next;
  logic        started;
  res_beat_t   due [$];
  int          fails = 0;

  assign fail_count = fails;

  function automatic void rebuild_table(input logic [7:0] prio);
    for (int i = 0; i < MAX_TASKS; i++) begin
      tbl[i] = '{id: 8'd0, prio: 8'd0, ready: 1'b0, wake: WAKE_NEVER};
    end
    tbl[0].id    = IDLE_TASK_ID;
    tbl[0].prio  = prio;
    tbl[0].ready = 1'b1;
    ticks_now  = '0;
    cur_id     = '0;
    n_switches = '0;
    n_tasks    = 1;
    id_next    = FIRST_NEW_ID;
    started    = 1'b0;
  endfunction

  // sorted insert; equal priorities queue behind the ones already there
  function automatic err_t insert_task(input logic [7:0] req_prio);
    int pos;
    if (n_tasks >= MAX_TASKS) return ERR_FULL;
    pos = n_tasks;
    for (int i = 0; i < n_tasks; i++) begin
      if (pos == n_tasks && tbl[i].prio > req_prio) pos = i;
    end
    for (int j = n_tasks; j > pos; j--) tbl[j] = tbl[j-1];
    tbl[pos] = '{id: id_next, prio: req_prio, ready: 1'b1, wake: WAKE_NEVER};
    // skip id 0 on wrap
    id_next = (id_next == LAST_ID) ? IDLE_TASK_ID : id_next + 8'd1;
    n_tasks++;
    return ERR_OK;
  endfunction

  function automatic err_t park_current(input logic [15:0] dly);
    bit hit;
    if (cur_id == 8'd0) return ERR_NO_TASK;
    hit = 1'b0;
    for (int i = 0; i < n_tasks; i++) begin
      if (!hit && tbl[i].id == cur_id) begin
        tbl[i].wake  = ticks_now + dly;
        tbl[i].ready = 1'b0;
        hit = 1'b1;
      end
    end
    return ERR_OK;
  endfunction

  function automatic void advance_tick();
    ticks_now = ticks_now + 16'd1;
    for (int i = 0; i < n_tasks; i++) begin
      if (tbl[i].wake == ticks_now) tbl[i].ready = 1'b1;
    end
  endfunction

  // first ready entry in table order wins; no ready entry keeps the current task
  function automatic logic pick_ready();
    int hit;
    hit = -1;
    for (int i = 0; i < n_tasks; i++) begin
      if (hit < 0 && tbl[i].ready) hit = i;
    end
    if (hit < 0 || tbl[hit].id == cur_id) return 1'b0;
    cur_id     = tbl[hit].id;
    n_switches = n_switches + 16'd1;
    return 1'b1;
  endfunction

  function automatic res_beat_t schedule_cmd(input cmd_beat_t c);
    res_beat_t r;
    err_t      err;
    logic      sw;
    err = ERR_OK;
    sw  = 1'b0;
    case (c.command)
      CMD_CREATE: err = insert_task(c.priority_req);
      CMD_DELAY:  err = park_current(c.delay_ticks);
      CMD_TICK:   advance_tick();
      CMD_RUN:    started = 1'b1;
      default:    ;
    endcase
    if (started) sw = pick_ready();
    r.running_task_id = cur_id;
    r.switched        = sw;
    r.error_code      = err;
    r.tick_value      = ticks_now;
    r.switch_count    = n_switches;
    r.task_total      = n_tasks[4:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_beat_t want;
    if (rst) begin
      idle_prio = IDLE_PRIO_RESET;
      rebuild_table(idle_prio);
      due.delete();
    end else begin
      if (cfg_we) begin
        idle_prio = cfg_wdata;
        rebuild_table(idle_prio);
      end
      if (res_valid && !res_stall) begin
        if (due.size() == 0) begin
          $error("result beat with no command outstanding");
          fails++;
        end else begin
          want = due.pop_front();
          if (res_data.running_task_id !== want.running_task_id) begin
            $error("running_task_id: expected %0d, got %0d",
                   want.running_task_id, res_data.running_task_id);
            fails++;
          end
          if (res_data.switched !== want.switched) begin
            $error("switched: expected %0d, got %0d", want.switched, res_data.switched);
            fails++;
          end
          if (res_data.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, res_data.error_code);
            fails++;
          end
          if (res_data.tick_value !== want.tick_value) begin
            $error("tick_value: expected %0d, got %0d", want.tick_value, res_data.tick_value);
            fails++;
          end
          if (res_data.switch_count !== want.switch_count) begin
            $error("switch_count: expected %0d, got %0d",
                   want.switch_count, res_data.switch_count);
            fails++;
          end
          if (res_data.task_total !== want.task_total) begin
            $error("task_total: expected %0d, got %0d", want.task_total, res_data.task_total);
            fails++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) due.push_back(schedule_cmd(cmd_data));
    end
    pending <= due.size();
  end

endmodule

`default_nettype wire

@@ tb/sv/priority_task_scheduler_tb.sv @@
// Testbench top for the priority task scheduler: stimulus, stalls, watchdog and verdict.
`default_nettype none

module priority_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASES         = 12;
  localparam int PHASE_BEATS    = 128;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_beat_t cmd_data  = '0;
  logic      res_valid;
  logic      res_stall = 1'b1;
  res_beat_t res_data;
  int        fail_count;
  int        pending;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;

  priority_task_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  pts_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_data   (cmd_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_span();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // valid stays up across back-to-back beats; it only drops for a gap
  task automatic send_cmd(input cmd_t op, input logic [7:0] prio, input logic [15:0] dly);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= '{command: op, priority_req: prio, delay_ticks: dly};
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_idle_prio(input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int count, input logic [7:0] idle);
    int         run_at;
    int         r;
    cmd_t       op;
    logic [7:0] prio;
    logic [15:0] dly;
    run_at = $urandom_range(0, 12);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (n == run_at)  op = CMD_RUN;
      else if (r < 22)  op = CMD_CREATE;
      else if (r < 47)  op = CMD_DELAY;
      else if (r < 90)  op = CMD_TICK;
      else              op = CMD_RUN;
      case ($urandom_range(0, 7))
        0:       prio = 8'd0;
        1:       prio = 8'hFF;
        2:       prio = idle;
        default: prio = 8'($urandom_range(0, 255));
      endcase
      // short delays so parked tasks wake again within the phase
      case ($urandom_range(0, 9))
        0:       dly = 16'd0;
        1:       dly = 16'hFFFF;
        2:       dly = 16'($urandom_range(0, 65535));
        default: dly = 16'($urandom_range(1, 12));
      endcase
      send_cmd(op, prio, dly);
    end
  endtask

  initial begin : stimulus
    logic [7:0] idle;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: idle priority at its reset value
    send_cmd(CMD_DELAY,  8'd0,   16'hFFFF);  // no task running yet
    send_cmd(CMD_TICK,   8'd0,   16'd0);
    send_cmd(CMD_CREATE, 8'd0,   16'd0);
    send_cmd(CMD_CREATE, 8'hFF,  16'd0);
    send_cmd(CMD_CREATE, 8'd100, 16'd0);     // ties with idle, goes behind it
    send_cmd(CMD_RUN,    8'd0,   16'd0);
    send_cmd(CMD_DELAY,  8'd0,   16'd3);
    repeat (3) send_cmd(CMD_TICK, 8'd0, 16'd0);
    send_cmd(CMD_DELAY,  8'd0,   16'd0);     // wakes only on counter wrap
    send_cmd(CMD_DELAY,  8'd0,   16'hFFFF);  // wake tick wraps
    send_cmd(CMD_RUN,    8'd0,   16'd0);
    // fill the table, then one create past full
    for (int k = 0; k < 13; k++) send_cmd(CMD_CREATE, 8'(k * 23 + 7), 16'd0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       idle = 8'd0;
        1:       idle = 8'hFF;
        2:       idle = 8'd100;
        3:       idle = 8'd1;
        4:       idle = 8'hFE;
        default: idle = 8'($urandom_range(0, 255));
      endcase
      calm = (p % 4 == 3);
      write_idle_prio(idle);
      random_phase(PHASE_BEATS, idle);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: stall for a random span before each beat
  initial begin : res_sink
    int gap;
    forever begin
      gap = idle_span();
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

`default_nettype wire
